// ===== hdl/ies_pkg.sv =====
// ----------------------------------------------------------------------------
// Intake and eject sequencer package
// Types, register codes and constants shared by the sequencer files.
// ----------------------------------------------------------------------------
package ies_pkg;

   localparam int COUNT_WIDTH    = 16;
   localparam int SPEED_WIDTH    = 16;
   localparam int DELAY_WIDTH    = 16;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CMP_WIDTH      = (COUNT_WIDTH > DELAY_WIDTH) ? COUNT_WIDTH : DELAY_WIDTH;

   localparam logic signed [SPEED_WIDTH-1:0] Q_ONE       = SPEED_WIDTH'(16384);
   localparam logic signed [SPEED_WIDTH-1:0] Q_MINUS_ONE = -SPEED_WIDTH'(16384);
   localparam logic signed [SPEED_WIDTH-1:0] ROLLER_STOP = '0;

   localparam logic signed [SPEED_WIDTH-1:0] HOLD_SPEED_RESET   = SPEED_WIDTH'(1638);
   localparam logic signed [SPEED_WIDTH-1:0] INTAKE_SPEED_RESET = SPEED_WIDTH'(8192);
   localparam logic signed [SPEED_WIDTH-1:0] EJECT_SPEED_RESET  = -SPEED_WIDTH'(8192);
   localparam logic [DELAY_WIDTH-1:0]        DELAY_RESET        = DELAY_WIDTH'(25);

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [3:0] {
      ST_AUTO = 4'd0,
      ST_IDLE = 4'd1,
      ST_HOLD = 4'd2,
      ST_HI1  = 4'd3,
      ST_HI2  = 4'd4,
      ST_HE1  = 4'd5,
      ST_HE2  = 4'd6,
      ST_HE3  = 4'd7,
      ST_HE4  = 4'd8,
      ST_CI1  = 4'd9,
      ST_CI2  = 4'd10,
      ST_CE1  = 4'd11,
      ST_CE2  = 4'd12,
      ST_CE3  = 4'd13
   } state_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HOLD_SPEED          = 3'd0,
      CSR_INTAKE_SPEED        = 3'd1,
      CSR_EJECT_SPEED         = 3'd2,
      CSR_HATCH_OPEN_DELAY    = 3'd3,
      CSR_HATCH_RETRACT_DELAY = 3'd4,
      CSR_CARGO_RUN_DELAY     = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic signed [SPEED_WIDTH-1:0] hold_speed;
      logic signed [SPEED_WIDTH-1:0] intake_speed;
      logic signed [SPEED_WIDTH-1:0] eject_speed;
      logic [DELAY_WIDTH-1:0]        hatch_open_delay;
      logic [DELAY_WIDTH-1:0]        hatch_retract_delay;
      logic [DELAY_WIDTH-1:0]        cargo_run_delay;
   } cfg_type;

   typedef struct packed {
      logic       cargo_sensor;
      logic       hatch_sensor_raw;
      logic       start_eject;
      logic       load_state;
      logic [3:0] new_state;
   } item_type;

   typedef struct packed {
      logic signed [SPEED_WIDTH-1:0] roller;
      logic                          grip;
      logic                          plunger;
      logic                          actuator;
   } levels_type;

   typedef struct packed {
      logic signed [SPEED_WIDTH-1:0] roller_drive;
      logic                          grip_closed_out;
      logic                          plunger_out;
      logic                          actuator_out;
      logic [3:0]                    phase;
      logic                          cargo_flag;
      logic                          hatch_flag;
   } rsp_type;

   function automatic logic signed [SPEED_WIDTH-1:0] sat_speed(
      input logic signed [SPEED_WIDTH-1:0] value
   );
      logic signed [SPEED_WIDTH-1:0] result;
      if (value > Q_ONE) begin
         result = Q_ONE;
      end else if (value < Q_MINUS_ONE) begin
         result = Q_MINUS_ONE;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

// ===== hdl/ies_req_if.sv =====
// ----------------------------------------------------------------------------
// Sequencer tick channel
// Carries one tick beat: sensor levels, eject request and optional state load.
// ----------------------------------------------------------------------------
interface ies_req_if;
   logic       valid;
   logic       ready;
   logic       cargo_sensor;
   logic       hatch_sensor_raw;
   logic       start_eject;
   logic       load_state;
   logic [3:0] new_state;

   modport source (
      output valid, cargo_sensor, hatch_sensor_raw, start_eject, load_state, new_state,
      input  ready
   );
   modport sink (
      input  valid, cargo_sensor, hatch_sensor_raw, start_eject, load_state, new_state,
      output ready
   );
endinterface

// ===== hdl/ies_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Sequencer result channel
// Carries one result beat: roller command, solenoid levels, phase and flags.
// ----------------------------------------------------------------------------
interface ies_rsp_if;
   import ies_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SPEED_WIDTH-1:0] roller_drive;
   logic                          grip_closed_out;
   logic                          plunger_out;
   logic                          actuator_out;
   logic [3:0]                    phase;
   logic                          cargo_flag;
   logic                          hatch_flag;

   modport source (
      output valid, roller_drive, grip_closed_out, plunger_out, actuator_out, phase,
             cargo_flag, hatch_flag,
      input  ready
   );
   modport sink (
      input  valid, roller_drive, grip_closed_out, plunger_out, actuator_out, phase,
             cargo_flag, hatch_flag,
      output ready
   );
endinterface

// ===== hdl/ies_step.sv =====
// ----------------------------------------------------------------------------
// Sequencer step logic
// Applies an optional state load, advances the elapsed counter and takes one
// step of the intake and eject state machine.
// ----------------------------------------------------------------------------
module ies_step (
   input  ies_pkg::state_type  state,
   input  ies_pkg::count_type  count,
   input  ies_pkg::levels_type levels,
   input  ies_pkg::cfg_type    cfg,
   input  ies_pkg::item_type   item,
   output ies_pkg::state_type  state_next,
   output ies_pkg::count_type  count_next,
   output ies_pkg::levels_type levels_next
);
   import ies_pkg::*;

   state_type cur_state;
   count_type count_inc;
   logic      hatch_present;
   logic      open_done;
   logic      retract_done;
   logic      run_done;

   always_comb begin
      if (item.load_state && (item.new_state <= ST_CE3)) begin
         cur_state = state_type'(item.new_state);
      end else begin
         cur_state = state;
      end
   end

   assign count_inc     = (count == '1) ? count : count + COUNT_WIDTH'(1);
   assign hatch_present = ~item.hatch_sensor_raw;
   assign open_done     = CMP_WIDTH'(count_inc) >= CMP_WIDTH'(cfg.hatch_open_delay);
   assign retract_done  = CMP_WIDTH'(count_inc) >= CMP_WIDTH'(cfg.hatch_retract_delay);
   assign run_done      = CMP_WIDTH'(count_inc) >= CMP_WIDTH'(cfg.cargo_run_delay);

   always_comb begin
      state_next = cur_state;
      unique case (cur_state)
         ST_HI1: begin
            state_next = ST_HI2;
         end
         ST_HI2: begin
            if (hatch_present) state_next = ST_IDLE;
         end
         ST_HE1: begin
            state_next = ST_HE2;
         end
         ST_HE2: begin
            if (item.start_eject) state_next = ST_HE3;
         end
         ST_HE3: begin
            if (open_done) state_next = ST_HE4;
         end
         ST_HE4: begin
            if (retract_done) state_next = ST_IDLE;
         end
         ST_CI1: begin
            state_next = ST_CI2;
         end
         ST_CI2: begin
            if (item.cargo_sensor) state_next = ST_HOLD;
         end
         ST_CE1: begin
            state_next = ST_CE2;
         end
         ST_CE2: begin
            if (item.start_eject) state_next = ST_CE3;
         end
         ST_CE3: begin
            if (run_done) state_next = ST_IDLE;
         end
         default: begin
            state_next = cur_state;
         end
      endcase
   end

   always_comb begin
      levels_next = levels;
      count_next  = count_inc;
      unique case (cur_state)
         ST_AUTO: begin
            levels_next.grip     = 1'b1;
            levels_next.actuator = 1'b1;
         end
         ST_IDLE: begin
            levels_next.roller = ROLLER_STOP;
         end
         ST_HOLD: begin
            levels_next.roller   = sat_speed(cfg.hold_speed);
            levels_next.actuator = 1'b0;
            levels_next.plunger  = 1'b0;
         end
         ST_HI1: begin
            levels_next.roller   = ROLLER_STOP;
            levels_next.actuator = 1'b1;
            levels_next.plunger  = 1'b0;
            levels_next.grip     = 1'b0;
         end
         ST_HI2: begin
            if (hatch_present) levels_next.grip = 1'b1;
         end
         ST_HE1: begin
            levels_next.roller = ROLLER_STOP;
         end
         ST_HE2: begin
            if (item.start_eject) begin
               levels_next.grip = 1'b0;
               count_next       = '0;
            end
         end
         ST_HE3: begin
            if (open_done) begin
               levels_next.plunger = 1'b1;
               count_next          = '0;
            end
         end
         ST_HE4: begin
            if (retract_done) begin
               levels_next.plunger  = 1'b0;
               levels_next.actuator = 1'b0;
            end
         end
         ST_CI1: begin
            levels_next.actuator = 1'b0;
            levels_next.grip     = 1'b0;
            levels_next.roller   = sat_speed(cfg.intake_speed);
         end
         ST_CI2: begin
            if (item.cargo_sensor) levels_next.roller = sat_speed(cfg.hold_speed);
         end
         ST_CE1: begin
            levels_next.actuator = 1'b0;
            levels_next.grip     = 1'b0;
         end
         ST_CE2: begin
            if (item.start_eject) begin
               levels_next.roller = sat_speed(cfg.eject_speed);
               count_next         = '0;
            end
         end
         ST_CE3: begin
            if (run_done) levels_next.roller = ROLLER_STOP;
         end
         default: begin
            levels_next = levels;
         end
      endcase
   end

endmodule

// ===== hdl/intake_eject_sequencer.sv =====
// ----------------------------------------------------------------------------
// Intake and eject sequencer
// Steps the cargo roller and hatch mechanism once for every tick beat.
// ----------------------------------------------------------------------------
// One tick beat is taken every clock cycle unless the result channel stalls;
// one result beat is given for each. The beat is held in an input register,
// the state machine step is taken as it moves to the result register, and the
// sequencer state is registered with it. The user must write registers through
// the csr port only while no beat is in flight; the block does not enforce it.
module intake_eject_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   ies_req_if.sink                              req_chan,
   ies_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  logic [ies_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ies_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import ies_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   count_type  count_ff;
   count_type  count_in;
   levels_type levels_ff;
   levels_type levels_in;
   item_type   item_ff;
   logic       item_valid_ff;
   logic       item_valid_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_take;
   logic       advance;

   assign advance          = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !item_valid_ff || advance;
   assign req_take         = req_chan.valid && req_chan.ready;
   assign item_valid_in    = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in     = advance || (rsp_valid_ff && !rsp_chan.ready);

   ies_step u_step (
      .state       (state_ff),
      .count       (count_ff),
      .levels      (levels_ff),
      .cfg         (cfg_ff),
      .item        (item_ff),
      .state_next  (state_in),
      .count_next  (count_in),
      .levels_next (levels_in)
   );

   always_comb begin
      rsp_in.roller_drive    = levels_in.roller;
      rsp_in.grip_closed_out = levels_in.grip;
      rsp_in.plunger_out     = levels_in.plunger;
      rsp_in.actuator_out    = levels_in.actuator;
      rsp_in.phase           = state_in;
      rsp_in.cargo_flag      = item_ff.cargo_sensor;
      rsp_in.hatch_flag      = ~item_ff.hatch_sensor_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         levels_ff     <= '{roller: ROLLER_STOP, grip: 1'b0, plunger: 1'b0, actuator: 1'b0};
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            state_ff  <= state_in;
            count_ff  <= count_in;
            levels_ff <= levels_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.cargo_sensor     <= req_chan.cargo_sensor;
         item_ff.hatch_sensor_raw <= req_chan.hatch_sensor_raw;
         item_ff.start_eject      <= req_chan.start_eject;
         item_ff.load_state       <= req_chan.load_state;
         item_ff.new_state        <= req_chan.new_state;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_speed          <= HOLD_SPEED_RESET;
         cfg_ff.intake_speed        <= INTAKE_SPEED_RESET;
         cfg_ff.eject_speed         <= EJECT_SPEED_RESET;
         cfg_ff.hatch_open_delay    <= DELAY_RESET;
         cfg_ff.hatch_retract_delay <= DELAY_RESET;
         cfg_ff.cargo_run_delay     <= DELAY_RESET;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            CSR_HOLD_SPEED:          cfg_ff.hold_speed          <= csr_wdata;
            CSR_INTAKE_SPEED:        cfg_ff.intake_speed        <= csr_wdata;
            CSR_EJECT_SPEED:         cfg_ff.eject_speed         <= csr_wdata;
            CSR_HATCH_OPEN_DELAY:    cfg_ff.hatch_open_delay    <= csr_wdata;
            CSR_HATCH_RETRACT_DELAY: cfg_ff.hatch_retract_delay <= csr_wdata;
            CSR_CARGO_RUN_DELAY:     cfg_ff.cargo_run_delay     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.roller_drive    = rsp_ff.roller_drive;
   assign rsp_chan.grip_closed_out = rsp_ff.grip_closed_out;
   assign rsp_chan.plunger_out     = rsp_ff.plunger_out;
   assign rsp_chan.actuator_out    = rsp_ff.actuator_out;
   assign rsp_chan.phase           = rsp_ff.phase;
   assign rsp_chan.cargo_flag      = rsp_ff.cargo_flag;
   assign rsp_chan.hatch_flag      = rsp_ff.hatch_flag;

endmodule

// ===== verif/intake_eject_sequencer_tb.sv =====
// -----------------------------------------------------------------------------
// Intake and eject sequencer testbench
// Sends tick beats through the sequencer while the sender pauses in bursts and
// the receiver stalls on its own pattern. Each result beat is predicted from an
// independent copy of the state machine and compared field by field. Directed
// ticks visit every phase first. Random well-formed sequences then run under
// several register settings, including a run with the largest delays in which
// the cargo run phase keeps waiting while spare state codes are loaded.
// -----------------------------------------------------------------------------
module intake_eject_sequencer_tb;
   import ies_pkg::*;

   class sequencer_scoreboard;
      cfg_type     regs;
      state_type   phase_now;
      count_type   elapsed;
      levels_type  levels;
      rsp_type     expected_q[$];
      int unsigned mismatches;
      int unsigned results_checked;
      int unsigned hatch_ejects;
      int unsigned cargo_ejects;
      logic [13:0] phases_seen;

      function new();
         regs.hold_speed = HOLD_SPEED_RESET;
         regs.intake_speed = INTAKE_SPEED_RESET;
         regs.eject_speed = EJECT_SPEED_RESET;
         regs.hatch_open_delay = DELAY_RESET;
         regs.hatch_retract_delay = DELAY_RESET;
         regs.cargo_run_delay = DELAY_RESET;
         phase_now = ST_IDLE;
         elapsed = '0;
         levels = '0;
         mismatches = 0;
         results_checked = 0;
         hatch_ejects = 0;
         cargo_ejects = 0;
         phases_seen = '0;
      endfunction

      function void write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                              input logic [CSR_DATA_WIDTH-1:0] data);
         case (index)
            CSR_HOLD_SPEED: regs.hold_speed = data;
            CSR_INTAKE_SPEED: regs.intake_speed = data;
            CSR_EJECT_SPEED: regs.eject_speed = data;
            CSR_HATCH_OPEN_DELAY: regs.hatch_open_delay = data;
            CSR_HATCH_RETRACT_DELAY: regs.hatch_retract_delay = data;
            CSR_CARGO_RUN_DELAY: regs.cargo_run_delay = data;
            default: ;
         endcase
      endfunction

      function logic signed [SPEED_WIDTH-1:0] applied_speed(
         input logic signed [SPEED_WIDTH-1:0] setting);
         int level;
         level = int'(setting);
         if (level > int'(Q_ONE)) begin
            level = int'(Q_ONE);
         end else if (level < -int'(Q_ONE)) begin
            level = -int'(Q_ONE);
         end
         return SPEED_WIDTH'(level);
      endfunction

      function void note_tick(input item_type beat);
         rsp_type want;
         if (beat.load_state && beat.new_state <= ST_CE3) begin
            phase_now = state_type'(beat.new_state);
         end
         if (elapsed != '1) begin
            elapsed = elapsed + 1'b1;
         end
         case (phase_now)
            ST_AUTO: begin
               levels.grip = 1'b1;
               levels.actuator = 1'b1;
            end
            ST_IDLE: begin
               levels.roller = ROLLER_STOP;
            end
            ST_HOLD: begin
               levels.roller = applied_speed(regs.hold_speed);
               levels.actuator = 1'b0;
               levels.plunger = 1'b0;
            end
            ST_HI1: begin
               levels.roller = ROLLER_STOP;
               levels.actuator = 1'b1;
               levels.plunger = 1'b0;
               levels.grip = 1'b0;
               phase_now = ST_HI2;
            end
            ST_HI2: begin
               if (!beat.hatch_sensor_raw) begin
                  levels.grip = 1'b1;
                  phase_now = ST_IDLE;
               end
            end
            ST_HE1: begin
               levels.roller = ROLLER_STOP;
               phase_now = ST_HE2;
            end
            ST_HE2: begin
               if (beat.start_eject) begin
                  levels.grip = 1'b0;
                  elapsed = '0;
                  phase_now = ST_HE3;
               end
            end
            ST_HE3: begin
               if (elapsed >= regs.hatch_open_delay) begin
                  levels.plunger = 1'b1;
                  elapsed = '0;
                  phase_now = ST_HE4;
               end
            end
            ST_HE4: begin
               if (elapsed >= regs.hatch_retract_delay) begin
                  levels.plunger = 1'b0;
                  levels.actuator = 1'b0;
                  phase_now = ST_IDLE;
                  hatch_ejects++;
               end
            end
            ST_CI1: begin
               levels.actuator = 1'b0;
               levels.grip = 1'b0;
               levels.roller = applied_speed(regs.intake_speed);
               phase_now = ST_CI2;
            end
            ST_CI2: begin
               if (beat.cargo_sensor) begin
                  levels.roller = applied_speed(regs.hold_speed);
                  phase_now = ST_HOLD;
               end
            end
            ST_CE1: begin
               levels.actuator = 1'b0;
               levels.grip = 1'b0;
               phase_now = ST_CE2;
            end
            ST_CE2: begin
               if (beat.start_eject) begin
                  levels.roller = applied_speed(regs.eject_speed);
                  elapsed = '0;
                  phase_now = ST_CE3;
               end
            end
            ST_CE3: begin
               if (elapsed >= regs.cargo_run_delay) begin
                  levels.roller = ROLLER_STOP;
                  phase_now = ST_IDLE;
                  cargo_ejects++;
               end
            end
            default: ;
         endcase
         want.roller_drive = levels.roller;
         want.grip_closed_out = levels.grip;
         want.plunger_out = levels.plunger;
         want.actuator_out = levels.actuator;
         want.phase = phase_now;
         want.cargo_flag = beat.cargo_sensor;
         want.hatch_flag = ~beat.hatch_sensor_raw;
         expected_q.push_back(want);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(input string what);
         if (mismatches < 40) begin
            $display("%0t: mismatch: %s", $time, what);
         end
         mismatches++;
      endtask

      task check_field(input string name, input logic signed [31:0] got,
                       input logic signed [31:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_checked, name, got, want));
         end
      endtask

      task check_result(input rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("result beat arrived with no tick waiting for it");
         end else begin
            want = expected_q.pop_front();
            results_checked++;
            phases_seen[want.phase] = 1'b1;
            check_field("roller_drive", got.roller_drive, want.roller_drive);
            check_field("grip_closed_out", got.grip_closed_out, want.grip_closed_out);
            check_field("plunger_out", got.plunger_out, want.plunger_out);
            check_field("actuator_out", got.actuator_out, want.actuator_out);
            check_field("phase", got.phase, want.phase);
            check_field("cargo_flag", got.cargo_flag, want.cargo_flag);
            check_field("hatch_flag", got.hatch_flag, want.hatch_flag);
         end
      endtask
   endclass

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES = 10;
   localparam int WAIT_TICKS = 40;
   localparam logic [3:0] SPARE_CODE_LO = 4'd14;
   localparam logic [3:0] SPARE_CODE_HI = 4'd15;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;
   logic                       rsp_take = 1'b0;
   logic [15:0]                stall_phase = '0;
   int unsigned                quiet_cycles = 0;
   int unsigned                burst_left = 0;
   int unsigned                ticks_sent = 0;
   sequencer_scoreboard        sb;

   ies_req_if req_chan();
   ies_rsp_if rsp_chan();

   intake_eject_sequencer dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   assign rsp_chan.ready = rsp_take;

   // The receiver moves through four stall patterns in turn.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[9:8])
         2'd0: rsp_take <= 1'b1;
         2'd1: rsp_take <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_take <= (stall_phase[2:0] != 3'd5);
         default: rsp_take <= ($urandom_range(0, 1) == 1);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            sb.note_tick({req_chan.cargo_sensor, req_chan.hatch_sensor_raw,
                          req_chan.start_eject, req_chan.load_state, req_chan.new_state});
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_result({rsp_chan.roller_drive, rsp_chan.grip_closed_out,
                             rsp_chan.plunger_out, rsp_chan.actuator_out, rsp_chan.phase,
                             rsp_chan.cargo_flag, rsp_chan.hatch_flag});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("intake_eject_sequencer_tb: done, errors");
            $finish;
         end
      end
   end

   function automatic item_type tick_of(input logic cargo, input logic hatch_raw,
                                        input logic eject, input logic load,
                                        input logic [3:0] code);
      return {cargo, hatch_raw, eject, load, code};
   endfunction

   function automatic item_type random_beat();
      item_type beat;
      beat.cargo_sensor = ($urandom_range(0, 3) == 0);
      beat.hatch_sensor_raw = ($urandom_range(0, 1) == 1);
      beat.start_eject = ($urandom_range(0, 2) == 0);
      beat.load_state = 1'b0;
      beat.new_state = 4'($urandom_range(0, 15));
      return beat;
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] rand_speed();
      if ($urandom_range(0, 1) == 0) begin
         return CSR_DATA_WIDTH'(int'($urandom_range(0, 32768)) - 16384);
      end
      return CSR_DATA_WIDTH'($urandom);
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] rand_delay();
      if ($urandom_range(0, 7) == 0) begin
         return CSR_DATA_WIDTH'($urandom_range(9, 60));
      end
      return CSR_DATA_WIDTH'($urandom_range(0, 8));
   endfunction

   task automatic send_tick(input item_type beat);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if ($urandom_range(0, 7) == 0) begin
            gap = $urandom_range(5, 20);
         end
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.cargo_sensor <= beat.cargo_sensor;
      req_chan.hatch_sensor_raw <= beat.hatch_sensor_raw;
      req_chan.start_eject <= beat.start_eject;
      req_chan.load_state <= beat.load_state;
      req_chan.new_state <= beat.new_state;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      ticks_sent++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(index, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_WIDTH-1:0] hold,
                            input logic [CSR_DATA_WIDTH-1:0] intake,
                            input logic [CSR_DATA_WIDTH-1:0] eject,
                            input logic [CSR_DATA_WIDTH-1:0] open_delay,
                            input logic [CSR_DATA_WIDTH-1:0] retract_delay,
                            input logic [CSR_DATA_WIDTH-1:0] run_delay);
      wait_drained();
      write_csr(CSR_HOLD_SPEED, hold);
      write_csr(CSR_INTAKE_SPEED, intake);
      write_csr(CSR_EJECT_SPEED, eject);
      write_csr(CSR_HATCH_OPEN_DELAY, open_delay);
      write_csr(CSR_HATCH_RETRACT_DELAY, retract_delay);
      write_csr(CSR_CARGO_RUN_DELAY, run_delay);
   endtask

   // Each sequence loads a starting phase and then runs plain ticks, with the
   // odd stray load mixed in as noise.
   task automatic run_random(input int unsigned count);
      int unsigned sent;
      int unsigned run_len;
      item_type    beat;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 59) == 0) begin
            wait_drained();
         end
         beat = random_beat();
         beat.load_state = 1'b1;
         case ($urandom_range(0, 9))
            0: beat.new_state = ST_HI1;
            1, 2: beat.new_state = ST_HE1;
            3: beat.new_state = ST_CI1;
            4, 5: beat.new_state = ST_CE1;
            6: beat.new_state = ST_HOLD;
            7: beat.new_state = ST_AUTO;
            8: beat.new_state = ST_IDLE;
            default: beat.new_state = 4'($urandom_range(0, 15));
         endcase
         send_tick(beat);
         run_len = $urandom_range(2, 40);
         repeat (run_len) begin
            beat = random_beat();
            beat.load_state = ($urandom_range(0, 24) == 0);
            send_tick(beat);
         end
         sent += run_len + 1;
      end
   endtask

   initial begin
      item_type beat;
      sb = new();
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_HOLD_SPEED;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.cargo_sensor <= 1'b0;
      req_chan.hatch_sensor_raw <= 1'b1;
      req_chan.start_eject <= 1'b0;
      req_chan.load_state <= 1'b0;
      req_chan.new_state <= ST_IDLE;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through every phase with the reset register values.
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b0, ST_IDLE));
      send_tick(tick_of(1'b1, 1'b0, 1'b1, 1'b1, SPARE_CODE_HI));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, SPARE_CODE_LO));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_AUTO));
      send_tick(tick_of(1'b1, 1'b1, 1'b1, 1'b0, ST_IDLE));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_HOLD));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_HI1));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b0, ST_IDLE));
      send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b0, ST_IDLE));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_HE1));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b0, ST_IDLE));
      send_tick(tick_of(1'b0, 1'b1, 1'b1, 1'b0, ST_IDLE));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_HE4));
      send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b1, ST_CI1));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b0, ST_IDLE));
      send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b0, ST_IDLE));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_CE1));
      send_tick(tick_of(1'b0, 1'b1, 1'b1, 1'b0, ST_IDLE));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_CE3));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_IDLE));
      send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b1, ST_HI2));
      send_tick(tick_of(1'b1, 1'b1, 1'b1, 1'b1, ST_HE2));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_HE3));
      send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b1, ST_CI2));
      send_tick(tick_of(1'b0, 1'b1, 1'b1, 1'b1, ST_CE2));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_IDLE));

      configure(Q_ONE, Q_MINUS_ONE, 16'h7FFF, '0, '0, '0);
      run_random(170);
      configure(16'h8000, 16'h4001, 16'hBFFF, 16'd1, 16'd2, 16'd3);
      run_random(170);
      configure(rand_speed(), rand_speed(), rand_speed(), rand_delay(), rand_delay(),
                rand_delay());
      run_random(170);

      // With the largest delays a delay phase keeps waiting while spare codes are loaded.
      configure(rand_speed(), rand_speed(), rand_speed(), '1, '1, '1);
      write_csr(CSR_SPARE_LO, CSR_DATA_WIDTH'($urandom));
      write_csr(CSR_SPARE_HI, CSR_DATA_WIDTH'($urandom));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_IDLE));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_CE3));
      repeat (WAIT_TICKS) begin
         beat = random_beat();
         beat.load_state = ($urandom_range(0, 1) == 1);
         beat.new_state = ($urandom_range(0, 1) == 1) ? SPARE_CODE_LO : SPARE_CODE_HI;
         send_tick(beat);
      end
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_HE3));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b0, ST_IDLE));
      send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, ST_IDLE));

      configure(rand_speed(), rand_speed(), rand_speed(), rand_delay(), rand_delay(),
                rand_delay());
      run_random(170);
      configure(rand_speed(), rand_speed(), rand_speed(), rand_delay(), rand_delay(),
                rand_delay());
      run_random(170);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("intake_eject_sequencer_tb: %0d ticks, %0d results, %0d of 14 phases",
               ticks_sent, sb.results_checked, $countones(sb.phases_seen));
      $display("intake_eject_sequencer_tb: %0d hatch, %0d cargo ejects, %0d mismatches",
               sb.hatch_ejects, sb.cargo_ejects, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("intake_eject_sequencer_tb: done, clean");
      end else begin
         $display("intake_eject_sequencer_tb: done, errors");
      end
      $finish;
   end
endmodule
